@@ src/fcr_pkg.sv @@
// Shared types and codes for the circular FIFO with replace-all.
// No dependencies; imported by the core and its storage.
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // Command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_REPLACE = 2'd2;
    localparam logic [1:0] CMD_STATUS  = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_REF_FULL  = 2'd1;
    localparam logic [1:0] STATUS_REF_EMPTY = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_WALK_RD  = 6'b000010,
        S_WALK_CMP = 6'b000100,
        S_RD_HEAD  = 6'b001000,
        S_RD_TAIL  = 6'b010000,
        S_LOAD     = 6'b100000
    } t_state;

endpackage

`default_nettype wire

@@ src/fcr_ram.sv @@
// Slot store of the FIFO: one write port and one registered read port.
// Depends on fcr_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module fcr_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire fcr_pkg::t_word i_wdata,
    input  wire logic [AW-1:0]  i_raddr,
    output fcr_pkg::t_word      o_rdata
);
    import fcr_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/circular_fifo_with_replace_core.sv @@
// Top level of the circular FIFO with replace-all: sequencer, pointers and
// output register. Depends on fcr_pkg and fcr_ram.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------------
//  input   | i_valid | o_ready | i_cmd, i_value, i_new_value
//  output  | o_valid | i_ready | o_head_word, o_tail_word, o_is_empty, o_is_full,
//          |         |         | o_status
//
// After acceptance a transaction reads the head slot, then the tail slot, and
// then loads the result once the output register is free; the tail read is
// skipped when the queue is empty afterwards. Everything goes through the single
// read port. For each occupied entry replace-all adds one read, then one shared
// compare with a conditional write back. Reset clears the pointers and control
// state only; the slot store is not cleared. A stalled result sits in the output
// register; o_ready stays low while an item is in progress.
`timescale 1ns / 1ps
`default_nettype none

module circular_fifo_with_replace_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output      logic           o_ready,
    input  wire logic [1:0]     i_cmd,
    input  wire fcr_pkg::t_word i_value,
    input  wire fcr_pkg::t_word i_new_value,
    output      logic           o_valid,
    input  wire logic           i_ready,
    output fcr_pkg::t_word      o_head_word,
    output fcr_pkg::t_word      o_tail_word,
    output      logic           o_is_empty,
    output      logic           o_is_full,
    output      logic [1:0]     o_status
);
    import fcr_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_ptr, n_ptr;
    t_word         r_val, n_val;
    t_word         r_nval, n_nval;
    logic [1:0]    r_status, n_status;
    t_word         r_head_word, n_head_word;

    logic          r_o_valid, n_o_valid;
    t_word         r_o_head, n_o_head;
    t_word         r_o_tail, n_o_tail;
    logic          r_o_empty, n_o_empty;
    logic          r_o_full, n_o_full;
    logic [1:0]    r_o_status, n_o_status;

    logic          we;
    logic [AW-1:0] waddr;
    t_word         wdata;
    logic [AW-1:0] raddr;
    t_word         rdata;

    logic          is_empty;
    logic          is_full;
    logic [AW-1:0] last_idx;
    logic          hit;

    assign is_empty = (r_head == r_tail);
    assign is_full  = (f_next(r_tail) == r_head);
    assign last_idx = (r_tail == '0) ? LAST_SLOT : r_tail - 1'b1;
    // The one comparator, shared by every step of the replace walk.
    assign hit      = (rdata == r_val);

    assign o_ready = (r_state == S_IDLE);

    fcr_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_ptr       = r_ptr;
        n_val       = r_val;
        n_nval      = r_nval;
        n_status    = r_status;
        n_head_word = r_head_word;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_head    = r_o_head;
        n_o_tail    = r_o_tail;
        n_o_empty   = r_o_empty;
        n_o_full    = r_o_full;
        n_o_status  = r_o_status;
        we          = 1'b0;
        waddr       = r_tail;
        wdata       = i_value;
        // Holding the read address on the newest slot keeps its word on
        // the read port while the result waits to be loaded.
        raddr       = last_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val    = i_value;
                    n_nval   = i_new_value;
                    n_status = STATUS_DONE;
                    n_state  = S_RD_HEAD;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (is_full) begin
                                n_status = STATUS_REF_FULL;
                            end else begin
                                we     = 1'b1;
                                n_tail = f_next(r_tail);
                            end
                        end
                        CMD_POP: begin
                            if (is_empty) begin
                                n_status = STATUS_REF_EMPTY;
                            end else begin
                                n_head = f_next(r_head);
                            end
                        end
                        CMD_REPLACE: begin
                            n_ptr = r_head;
                            if (!is_empty) begin
                                n_state = S_WALK_RD;
                            end
                        end
                        CMD_STATUS: begin
                            n_status = STATUS_DONE;
                        end
                        default: begin
                            n_status = STATUS_DONE;
                        end
                    endcase
                end
            end
            S_WALK_RD: begin
                raddr   = r_ptr;
                n_state = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                if (hit) begin
                    we    = 1'b1;
                    waddr = r_ptr;
                    wdata = r_nval;
                end
                n_ptr = f_next(r_ptr);
                if (f_next(r_ptr) == r_tail) begin
                    n_state = S_RD_HEAD;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_RD_HEAD: begin
                raddr = r_head;
                if (is_empty) begin
                    n_head_word = '0;
                    n_state     = S_LOAD;
                end else begin
                    n_state = S_RD_TAIL;
                end
            end
            S_RD_TAIL: begin
                n_head_word = rdata;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_head   = r_head_word;
                    n_o_tail   = is_empty ? '0 : rdata;
                    n_o_empty  = is_empty;
                    n_o_full   = is_full;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_val       <= n_val;
        r_nval      <= n_nval;
        r_status    <= n_status;
        r_head_word <= n_head_word;
        r_o_head    <= n_o_head;
        r_o_tail    <= n_o_tail;
        r_o_empty   <= n_o_empty;
        r_o_full    <= n_o_full;
        r_o_status  <= n_o_status;
    end

    assign o_valid     = r_o_valid;
    assign o_head_word = r_o_head;
    assign o_tail_word = r_o_tail;
    assign o_is_empty  = r_o_empty;
    assign o_is_full   = r_o_full;
    assign o_status    = r_o_status;

endmodule

`default_nettype wire

@@ tb/fcr_ring_checker.sv @@
// Scoreboard for the circular FIFO with replace-all: it mirrors the ring in a
// behavioural model, queues one expected report per accepted command and
// compares each delivered report. Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_ring_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [1:0] i_cmd,
    input  fcr_pkg::t_word  i_value,
    input  fcr_pkg::t_word  i_new_value,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  fcr_pkg::t_word  i_head_word,
    input  fcr_pkg::t_word  i_tail_word,
    input  wire logic       i_is_empty,
    input  wire logic       i_is_full,
    input  wire logic [1:0] i_status,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    import fcr_pkg::*;

    typedef struct packed {
        t_word      head_word;
        t_word      tail_word;
        logic       is_empty;
        logic       is_full;
        logic [1:0] status;
    } t_ring_report;

    t_word        ring_store [DEPTH];
    int unsigned  head_idx;
    int unsigned  tail_idx;
    t_ring_report expected_reports [$];
    int           mismatches;
    int           checked;

    function automatic int unsigned ring_next(int unsigned idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    // Applies one command to the mirrored ring and returns the report it causes.
    function automatic t_ring_report ring_apply(logic [1:0] cmd, t_word match_word,
                                                t_word subst_word);
        t_ring_report rep;
        int unsigned  idx;
        rep = '0;
        rep.status = STATUS_DONE;
        case (cmd)
            CMD_PUSH: begin
                if (ring_next(tail_idx) == head_idx) begin
                    rep.status = STATUS_REF_FULL;
                end else begin
                    ring_store[tail_idx] = match_word;
                    tail_idx = ring_next(tail_idx);
                end
            end
            CMD_POP: begin
                if (head_idx == tail_idx) begin
                    rep.status = STATUS_REF_EMPTY;
                end else begin
                    head_idx = ring_next(head_idx);
                end
            end
            CMD_REPLACE: begin
                // The walk covers only occupied slots and wraps past the last one.
                idx = head_idx;
                while (idx != tail_idx) begin
                    if (ring_store[idx] == match_word) begin
                        ring_store[idx] = subst_word;
                    end
                    idx = ring_next(idx);
                end
            end
            CMD_STATUS: ;
        endcase
        rep.is_empty = (head_idx == tail_idx);
        rep.is_full  = (ring_next(tail_idx) == head_idx);
        if (!rep.is_empty) begin
            rep.head_word = ring_store[head_idx];
            rep.tail_word = ring_store[(tail_idx == 0) ? DEPTH - 1 : tail_idx - 1];
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_ring_report want;
        if (!i_rst_n) begin
            head_idx   = 0;
            tail_idx   = 0;
            mismatches = 0;
            checked    = 0;
            expected_reports.delete();
        end else begin
            // A report can never belong to the command accepted on the same
            // edge, so the comparison comes first.
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("[%0t] Unexpected report: head %0d tail %0d",
                                 $realtime, i_head_word, i_tail_word);
                        $display("    empty %0b full %0b status %0d",
                                 i_is_empty, i_is_full, i_status);
                    end
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_head_word !== want.head_word || i_tail_word !== want.tail_word ||
                        i_is_empty !== want.is_empty || i_is_full !== want.is_full ||
                        i_status !== want.status) begin
                        if (mismatches < 10) begin
                            $display("[%0t] Report %0d differs", $realtime, checked);
                            $display("    expected head %0d tail %0d empty %0b full %0b status %0d",
                                     want.head_word, want.tail_word, want.is_empty,
                                     want.is_full, want.status);
                            $display("    actual   head %0d tail %0d empty %0b full %0b status %0d",
                                     i_head_word, i_tail_word, i_is_empty, i_is_full,
                                     i_status);
                        end
                        mismatches++;
                    end
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_reports.push_back(ring_apply(i_cmd, i_value, i_new_value));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_reports.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the circular FIFO with replace-all: clock, reset, command
// stimulus and result-side back-pressure, with the verdict at the end.
// Depends on fcr_pkg, circular_fifo_with_replace_core and fcr_ring_checker.
`timescale 1ns / 1ps

module tb_top;

    import fcr_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          CYCLE_LIMIT  = 500000;

    typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} t_phase;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_cmd;
    t_word      i_value;
    t_word      i_new_value;
    logic       o_valid;
    logic       i_ready;
    t_word      o_head_word;
    t_word      o_tail_word;
    logic       o_is_empty;
    logic       o_is_full;
    logic [1:0] o_status;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_by_cmd [4];

    circular_fifo_with_replace_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .i_new_value(i_new_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_head_word(o_head_word),
        .o_tail_word(o_tail_word),
        .o_is_empty (o_is_empty),
        .o_is_full  (o_is_full),
        .o_status   (o_status)
    );

    fcr_ring_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_new_value (i_new_value),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_head_word (o_head_word),
        .i_tail_word (o_tail_word),
        .i_is_empty  (o_is_empty),
        .i_is_full   (o_is_full),
        .i_status    (o_status),
        .o_fail_count(fail_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d reports outstanding",
                 cycles, pending_count);
        $display("Verification failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Entered just after a rising edge; returns on the edge that accepts the
    // transaction, with valid still high.
    task automatic send_item(input logic [1:0] cmd, input t_word match_word,
                             input t_word subst_word, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_cmd       <= 2'($urandom);
            i_value     <= t_word'($urandom);
            i_new_value <= t_word'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_cmd       <= cmd;
        i_value     <= match_word;
        i_new_value <= subst_word;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sent_by_cmd[cmd]++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Result-side back-pressure: runs of ready, with stalls between them.
    initial begin : sink_pacing
        int run;
        int stall;
        i_ready = 1'b0;
        forever begin
            run = $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) run = $urandom_range(50, 150);
            repeat (run) begin
                @(negedge i_clk);
                i_ready <= 1'b1;
            end
            stall = idle_len();
            repeat (stall) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_phase     phase;
        int         phase_left;
        bit         steady;
        int         roll;
        logic [1:0] cmd;
        t_word      pool [4];
        t_word      match_word;
        t_word      subst_word;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = CMD_STATUS;
        i_value     = '0;
        i_new_value = '0;
        foreach (sent_by_cmd[k]) sent_by_cmd[k] = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every command on an empty queue, the word extremes, a fill
        // to capacity, a refused push, the tail pointer wrapping to zero and a
        // replace walk that wraps past the end of the store.
        send_item(CMD_STATUS, '0, '0, 0);
        send_item(CMD_POP, '1, '1, 0);
        send_item(CMD_REPLACE, '0, 32'sd5, 0);
        send_item(CMD_PUSH, 32'sh8000_0000, '0, 0);
        send_item(CMD_PUSH, 32'sh7fff_ffff, '1, 0);
        send_item(CMD_PUSH, '1, '0, 0);
        send_item(CMD_PUSH, '0, '1, 0);
        for (int k = 0; k < DEPTH - 5; k++) begin
            match_word = (k % 3 == 0) ? 32'sh7fff_ffff : t_word'($urandom);
            send_item(CMD_PUSH, match_word, '0, idle_len());
        end
        send_item(CMD_PUSH, 32'sd1, '0, 0);
        send_item(CMD_POP, '0, '0, 0);
        send_item(CMD_POP, '0, '0, 0);
        send_item(CMD_PUSH, 32'sh7fff_ffff, '0, 0);
        send_item(CMD_PUSH, 32'sh7fff_ffff, '0, 0);
        send_item(CMD_REPLACE, 32'sh7fff_ffff, 32'shaaaa_aaaa, 0);

        // Random: phases that lean towards filling or draining so that the
        // full and empty boundaries and pointer wrap are crossed many times.
        // A small pool of words per phase makes replace hits frequent.
        phase_left = 0;
        phase      = PHASE_MIXED;
        steady     = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase      = t_phase'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 60);
                steady     = ($urandom_range(0, 3) == 0);
                foreach (pool[k]) pool[k] = pick_word();
                if (phase == PHASE_DRAIN && $urandom_range(0, 3) == 0) hold_until_drained();
            end
            phase_left--;
            if (n == RANDOM_ITEMS / 2) hold_until_drained();

            roll = $urandom_range(0, 99);
            case (phase)
                PHASE_FILL:  cmd = (roll < 60) ? CMD_PUSH : (roll < 75) ? CMD_POP :
                                   (roll < 90) ? CMD_REPLACE : CMD_STATUS;
                PHASE_DRAIN: cmd = (roll < 15) ? CMD_PUSH : (roll < 75) ? CMD_POP :
                                   (roll < 90) ? CMD_REPLACE : CMD_STATUS;
                default:     cmd = (roll < 35) ? CMD_PUSH : (roll < 70) ? CMD_POP :
                                   (roll < 90) ? CMD_REPLACE : CMD_STATUS;
            endcase
            match_word = ($urandom_range(0, 99) < 60) ? pool[$urandom_range(0, 3)]
                                                      : t_word'($urandom);
            subst_word = ($urandom_range(0, 99) < 50) ? pool[$urandom_range(0, 3)]
                                                      : t_word'($urandom);
            send_item(cmd, match_word, subst_word, steady ? 0 : idle_len());
        end

        hold_until_drained();
        repeat (60) @(negedge i_clk);

        $display("Run covered %0d transactions: %0d push, %0d pop, %0d replace, %0d status.",
                 sent_by_cmd[CMD_PUSH] + sent_by_cmd[CMD_POP] + sent_by_cmd[CMD_REPLACE] +
                 sent_by_cmd[CMD_STATUS], sent_by_cmd[CMD_PUSH], sent_by_cmd[CMD_POP],
                 sent_by_cmd[CMD_REPLACE], sent_by_cmd[CMD_STATUS]);
        $display("%0d reports compared, %0d mismatched or unexpected, %0d outstanding.",
                 checked_count, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
